// File: rtl/spq_pkg.sv
package spq_pkg;

  // Number of cells in the queue.
  localparam int unsigned DEPTH = 16;

  localparam int unsigned DATA_W = 32;

  // Action codes of an input beat.
  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [1:0] ACT_CHANGE  = 2'd2;

  // Status codes of a result beat.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  // Operation that every cell carries out.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  // One queue slot.
  typedef struct packed {
    logic                     valid;
    logic        [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  // Command broadcast from the controller to the row of cells.
  typedef struct packed {
    cell_op_e                 op;
    logic        [DATA_W-1:0] key;
    logic        [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } cell_cmd_t;

endpackage

// File: rtl/sorted_priority_queue.sv
// Sorted priority queue of DEPTH (value, priority) entries held in a row of cells,
// head in cell 0, lowest priority number first and equal priorities in arrival order.
// Enqueue and dequeue act on the whole row at once: every cell compares against
// the broadcast item in parallel and shifts toward or away from its neighbor.
// Change-priority works in steps: the first removes the first entry whose value
// matches, the second reinserts it with the new priority after any equals once
// out_free allows. One result beat is returned per input beat; a new input beat
// is taken while the last result waits only if that result is taken in the same cycle.
module sorted_priority_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic signed [spq_pkg::DATA_W-1:0] item_value_i,
  input  logic signed [spq_pkg::DATA_W-1:0] item_priority_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [spq_pkg::DATA_W-1:0] result_value_o,
  output logic [1:0]                        status_o,
  output logic                              now_empty_o
);
  import spq_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_INSERT = 1'b1;

  logic state_q, state_d;
  logic [DATA_W-1:0] hold_value_q, hold_value_d;
  logic signed [DATA_W-1:0] hold_prio_q, hold_prio_d;

  logic out_valid_q, out_valid_d;
  logic [DATA_W-1:0] result_q, result_d;
  logic [1:0] status_q, status_d;
  logic now_empty_q, now_empty_d;

  cell_cmd_t cmd;
  cell_op_e  cell_op;
  logic      head_rm;
  entry_t    entry [DEPTH];
  logic      ge    [DEPTH];
  logic      rm    [DEPTH];

  logic out_free, accept, out_load;
  logic q_empty, q_full, found;

  assign q_empty = !entry[0].valid;
  assign q_full  = entry[DEPTH-1].valid;
  assign found   = rm[DEPTH-1];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Broadcast item: the held entry while reinserting, otherwise the input beat.
  // A dequeue marks every cell for removal from the head on.
  assign head_rm = (state_q == ST_IDLE) && (action_i == ACT_DEQUEUE);
  assign cmd = '{op:    cell_op,
                 key:   item_value_i,
                 value: (state_q == ST_INSERT) ? hold_value_q : item_value_i,
                 prio:  (state_q == ST_INSERT) ? hold_prio_q : item_priority_i};

  // Row of cells, each linked to both neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_ge, rm_in;
    if (i == 0) begin : g_head
      assign left_e  = '0;
      assign left_ge = 1'b0;
      assign rm_in   = head_rm;
    end else begin : g_body
      assign left_e  = entry[i-1];
      assign left_ge = ge[i-1];
      assign rm_in   = rm[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid
      assign right_e = entry[i+1];
    end
    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    (left_e),
      .left_ge_i (left_ge),
      .right_i   (right_e),
      .rm_i      (rm_in),
      .entry_o   (entry[i]),
      .ge_o      (ge[i]),
      .rm_o      (rm[i])
    );
  end

  // Sequencer: decodes an accepted beat, or finishes the reinsert of a change.
  always_comb begin
    state_d      = state_q;
    hold_value_d = hold_value_q;
    hold_prio_d  = hold_prio_q;
    cell_op      = CELL_HOLD;
    out_load     = 1'b0;
    result_d     = '0;
    status_d     = STAT_OK;
    now_empty_d  = q_empty;

    if (state_q == ST_INSERT) begin
      if (out_free) begin
        cell_op     = CELL_INSERT;
        out_load    = 1'b1;
        now_empty_d = 1'b0;
        state_d     = ST_IDLE;
      end
    end else if (accept) begin
      case (action_i)
        ACT_ENQUEUE: begin
          out_load = 1'b1;
          if (q_full) begin
            status_d = STAT_FULL;
          end else begin
            cell_op     = CELL_INSERT;
            now_empty_d = 1'b0;
          end
        end
        ACT_DEQUEUE: begin
          out_load = 1'b1;
          if (q_empty) begin
            result_d = '1;
            status_d = STAT_EMPTY;
          end else begin
            cell_op     = CELL_REMOVE;
            result_d    = entry[0].value;
            now_empty_d = !entry[1].valid;
          end
        end
        ACT_CHANGE: begin
          if (q_empty) begin
            out_load = 1'b1;
            status_d = STAT_EMPTY;
          end else if (!found) begin
            out_load = 1'b1;
            status_d = STAT_NOT_FOUND;
          end else begin
            cell_op      = CELL_REMOVE;
            hold_value_d = item_value_i;
            hold_prio_d  = item_priority_i;
            state_d      = ST_INSERT;
          end
        end
        default: begin
          out_load = 1'b1;
        end
      endcase
    end
  end

  // Result beat register.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_value_q <= hold_value_d;
    hold_prio_q  <= hold_prio_d;
    if (out_load) begin
      result_q    <= result_d;
      status_q    <= status_d;
      now_empty_q <= now_empty_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign status_o       = status_q;
  assign now_empty_o    = now_empty_q;

endmodule

// File: rtl/spq_cell.sv
module spq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_pkg::cell_cmd_t cmd_i,
  input  spq_pkg::entry_t   left_i,
  input  logic              left_ge_i,
  input  spq_pkg::entry_t   right_i,
  input  logic              rm_i,
  output spq_pkg::entry_t   entry_o,
  output logic              ge_o,
  output logic              rm_o
);
  import spq_pkg::*;

  logic                     valid_q, valid_d;
  logic        [DATA_W-1:0] value_q, value_d;
  logic signed [DATA_W-1:0] prio_q, prio_d;

  // This slot sits at or past the insertion point: empty, or strictly lower priority.
  assign ge_o = !valid_q || (prio_q > cmd_i.prio);

  // Removal marker: set from the first slot holding the key onward.
  assign rm_o = rm_i || (valid_q && (value_q == cmd_i.key));

  // Next slot contents.
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    prio_d  = prio_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (left_ge_i) begin
          valid_d = left_i.valid;
          value_d = left_i.value;
          prio_d  = left_i.prio;
        end else if (ge_o) begin
          valid_d = 1'b1;
          value_d = cmd_i.value;
          prio_d  = cmd_i.prio;
        end
      end
      CELL_REMOVE: begin
        if (rm_o) begin
          valid_d = right_i.valid;
          value_d = right_i.value;
          prio_d  = right_i.prio;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.value = value_q;
  assign entry_o.prio  = prio_q;

endmodule
